>>> src/hpi_pkg.sv
// Shared types, constants and the CORDIC angle table for the pose integrator.
package hpi_pkg;

  localparam int AMT_W  = 18;   // signed distance or degrees, Q8
  localparam int HEAD_W = 17;   // heading, degrees Q8
  localparam int XY_W   = 33;   // CORDIC vector components, Q30 with headroom
  localparam int Z_W    = 25;   // CORDIC residual angle, degrees Q16
  localparam int ATAN_W = 23;
  localparam int TURN_W = 19;   // heading plus a signed amount before wrapping

  // Operation codes carried in tuser.
  localparam logic FUNC_DRIVE = 1'b0;
  localparam logic FUNC_TURN  = 1'b1;

  localparam logic [HEAD_W-1:0] QUARTER_TURN = 17'd23040;
  localparam logic [HEAD_W-1:0] HALF_TURN    = 17'd46080;
  localparam logic [HEAD_W-1:0] THREE_QUARTER = 17'd69120;
  localparam logic signed [TURN_W-1:0] FULL_TURN = 19'sd92160;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_east;
    logic acc_north;
  } hpi_acc_ctl_t;

  // atan(2^-i) in degrees Q16.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/hpi_cordic.sv
// Iterative CORDIC rotator: one shift-add micro-rotation per clock.
module hpi_cordic #(
  parameter int STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [hpi_pkg::Z_W-1:0]    z0,
  output logic                              done,
  output logic signed [hpi_pkg::XY_W-1:0]   x_out,
  output logic signed [hpi_pkg::XY_W-1:0]   y_out
);

  localparam int IW = $clog2(STEPS);

  logic signed [hpi_pkg::XY_W-1:0] x_r, y_r, xs, ys;
  logic signed [hpi_pkg::Z_W-1:0]  z_r, ang;
  logic [IW-1:0]                   cnt_r;
  logic                            busy_r, done_r;

  // Arithmetic shifts round toward minus infinity, as the rotation requires.
  assign xs  = x_r >>> cnt_r;
  assign ys  = y_r >>> cnt_r;
  assign ang = $signed({2'b00, hpi_pkg::atan_q16(5'(cnt_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == IW'(STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= hpi_pkg::CORDIC_GAIN_Q30;
      y_r   <= '0;
      z_r   <= z0;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (!z_r[hpi_pkg::Z_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule

>>> src/hpi_pose_acc.sv
// Shared multiplier and saturating position accumulator for east and north.
module hpi_pose_acc #(
  parameter int POS_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hpi_pkg::hpi_acc_ctl_t              ctl,
  input  logic signed [hpi_pkg::AMT_W-1:0]   amount,
  input  logic signed [hpi_pkg::XY_W-1:0]    mul_op,
  output logic signed [POS_WIDTH-1:0]        east,
  output logic signed [POS_WIDTH-1:0]        north
);

  localparam int PW = hpi_pkg::AMT_W + hpi_pkg::XY_W;
  localparam int DW = PW - 30;
  localparam int SW = ((POS_WIDTH > DW) ? POS_WIDTH : DW) + 1;
  localparam logic signed [PW-1:0] RND = {{(PW - 30){1'b0}}, 1'b1, {29{1'b0}}};
  localparam logic signed [SW-1:0] POS_HI = {{(SW - POS_WIDTH + 1){1'b0}},
                                              {(POS_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] POS_LO = ~POS_HI;

  logic signed [PW-1:0]        prod_r, rsum;
  logic signed [DW-1:0]        delta;
  logic signed [POS_WIDTH-1:0] east_r, north_r, base, sat;
  logic signed [SW-1:0]        sum;

  // Q38 product back to Q8, rounding half up; the upper bits are a floor shift.
  assign rsum  = prod_r + RND;
  assign delta = $signed(rsum[PW-1:30]);
  assign base  = ctl.acc_east ? east_r : north_r;
  assign sum   = $signed({{(SW - POS_WIDTH){base[POS_WIDTH-1]}}, base})
               + $signed({{(SW - DW){delta[DW-1]}}, delta});

  always_comb begin
    if (sum > POS_HI) begin
      sat = POS_HI[POS_WIDTH-1:0];
    end else if (sum < POS_LO) begin
      sat = POS_LO[POS_WIDTH-1:0];
    end else begin
      sat = sum[POS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= amount * mul_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      east_r  <= '0;
      north_r <= '0;
    end else begin
      if (ctl.acc_east) begin
        east_r <= sat;
      end
      if (ctl.acc_north) begin
        north_r <= sat;
      end
    end
  end

  assign east  = east_r;
  assign north = north_r;

endmodule

>>> src/heading_pose_integrator_core.sv
// Top level of the dead-reckoning pose integrator: sequencer, heading and output word.
//
//  channel | direction | word contents (lowest bit up)
//  --------+-----------+-------------------------------------------------------
//  in_     | slave     | tuser: func; tdata: amount[17:0]
//  out_    | master    | tdata: pos_x[31:0], pos_y[63:32], heading_deg[80:64]
//
// A drive word passes from acceptance to the result register through the
// CORDIC rotator, which runs one micro-rotation a cycle, then through the
// shared multiplier, which serves sine and cosine in turn.
// A turn word is wrapped into one turn by one wrap correction per cycle.
// Reset clears the pose to the origin facing north. in_tready is high only
// while the sequencer is idle; a new word may be taken while a result waits.

module heading_pose_integrator_core #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // amount[17:0], zero pad
  input  logic [0:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // pos_x, pos_y, heading_deg, zero pad
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROT  = 3'd1;
  localparam logic [2:0] ST_MULS = 3'd2;
  localparam logic [2:0] ST_MULC = 3'd3;
  localparam logic [2:0] ST_ACCN = 3'd4;
  localparam logic [2:0] ST_WRAP = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int   EW = (POS_WIDTH > 32) ? POS_WIDTH : 32;

  logic [2:0]                          state_r, state_nxt;
  logic                                accept;
  logic signed [hpi_pkg::AMT_W-1:0]    amount_r;
  logic [hpi_pkg::HEAD_W-1:0]          facing_r;
  logic signed [hpi_pkg::TURN_W-1:0]   turn_r;
  logic [1:0]                          quad_r, quad;
  logic [hpi_pkg::HEAD_W-1:0]          resid;
  logic signed [hpi_pkg::Z_W-1:0]      z0;
  logic                                cordic_start, cordic_done;
  logic signed [hpi_pkg::XY_W-1:0]     cx, cy, sin_v, cos_v, mul_op;
  hpi_pkg::hpi_acc_ctl_t               acc_ctl;
  logic signed [POS_WIDTH-1:0]         east, north;
  logic signed [EW-1:0]                east_ext, north_ext;
  logic                                out_free;
  logic                                out_valid_r;
  logic [87:0]                         out_data_r;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Quadrant reduction of the current heading.
  always_comb begin
    if (facing_r >= hpi_pkg::THREE_QUARTER) begin
      quad  = 2'd3;
      resid = facing_r - hpi_pkg::THREE_QUARTER;
    end else if (facing_r >= hpi_pkg::HALF_TURN) begin
      quad  = 2'd2;
      resid = facing_r - hpi_pkg::HALF_TURN;
    end else if (facing_r >= hpi_pkg::QUARTER_TURN) begin
      quad  = 2'd1;
      resid = facing_r - hpi_pkg::QUARTER_TURN;
    end else begin
      quad  = 2'd0;
      resid = facing_r;
    end
  end

  // The residue is below a quarter turn, so the starting angle is never negative.
  assign z0           = $signed({2'b00, resid[14:0], 8'd0});
  assign cordic_start = accept && (in_tuser[0] != hpi_pkg::FUNC_TURN);

  hpi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .z0    (z0),
    .done  (cordic_done),
    .x_out (cx),
    .y_out (cy)
  );

  // Map the first-quadrant rotation back onto the full circle.
  always_comb begin
    case (quad_r)
      2'd0: begin
        sin_v = cy;
        cos_v = cx;
      end
      2'd1: begin
        sin_v = cx;
        cos_v = -cy;
      end
      2'd2: begin
        sin_v = -cy;
        cos_v = -cx;
      end
      default: begin
        sin_v = -cx;
        cos_v = cy;
      end
    endcase
  end

  assign mul_op            = (state_r == ST_MULC) ? cos_v : sin_v;
  assign acc_ctl.mul_en    = (state_r == ST_MULS) || (state_r == ST_MULC);
  assign acc_ctl.acc_east  = (state_r == ST_MULC);
  assign acc_ctl.acc_north = (state_r == ST_ACCN);

  hpi_pose_acc #(
    .POS_WIDTH (POS_WIDTH)
  ) u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .amount (amount_r),
    .mul_op (mul_op),
    .east   (east),
    .north  (north)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser[0] == hpi_pkg::FUNC_TURN) ? ST_WRAP : ST_ROT;
        end
      end
      ST_ROT: begin
        if (cordic_done) begin
          state_nxt = ST_MULS;
        end
      end
      ST_MULS: state_nxt = ST_MULC;
      ST_MULC: state_nxt = ST_ACCN;
      ST_ACCN: state_nxt = ST_DONE;
      ST_WRAP: begin
        if (!turn_r[hpi_pkg::TURN_W-1] && turn_r < hpi_pkg::FULL_TURN) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      facing_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_WRAP && !turn_r[hpi_pkg::TURN_W-1]
          && turn_r < hpi_pkg::FULL_TURN) begin
        facing_r <= turn_r[hpi_pkg::HEAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      amount_r <= $signed(in_tdata[hpi_pkg::AMT_W-1:0]);
      quad_r   <= quad;
      turn_r   <= $signed({2'b00, facing_r})
                + $signed({in_tdata[hpi_pkg::AMT_W-1], in_tdata[hpi_pkg::AMT_W-1:0]});
    end else if (state_r == ST_WRAP) begin
      // The sum stays within two turns of the range, so a few corrections do.
      if (turn_r[hpi_pkg::TURN_W-1]) begin
        turn_r <= turn_r + hpi_pkg::FULL_TURN;
      end else if (turn_r >= hpi_pkg::FULL_TURN) begin
        turn_r <= turn_r - hpi_pkg::FULL_TURN;
      end
    end
  end

  assign east_ext  = EW'(east);
  assign north_ext = EW'(north);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {7'd0, facing_r, north_ext[31:0], east_ext[31:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> src/hpi_checker.sv
// Port-level checks for the pose integrator, bound to the top level.
module hpi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped before it was taken");

  // An accepted word takes the sequencer out of the idle state and drops in_tready.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a word was accepted");

  // The reported heading is always wrapped into one turn.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[80:64] < 17'd92160)
    else $error("heading outside one revolution");

  // Reset leaves no result on offer.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind heading_pose_integrator_core hpi_checker u_hpi_checker (.*);
